@@ sv/lers_pkg.sv @@
`default_nettype none

package lers_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int SECTOR_BITS  = 48;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_SECTOR_W  = 48;
  localparam int OUT_SECTOR_W = 48;
  localparam int OUT_COUNT_W  = 6;
  localparam int IN_DATA_W    = ((IN_SECTOR_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = OUT_SECTOR_W + 1 + OUT_COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic {
    OP_ADD      = 1'b0,
    OP_DISPATCH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_RES
  } state_t;

endpackage

`default_nettype wire

@@ sv/lers_ram.sv @@
`default_nettype none

module lers_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/look_elevator_request_scheduler.sv @@
// LOOK elevator scheduler for pending disk sector requests.
//
// Input channel (in_*): one request per handshake. in_tuser is the opcode
// (0 add, 1 dispatch), in_tdata carries the sector to add.
// Result channel (out_*): exactly one result per request. out_tuser is the
// status, out_tdata carries served sector, direction and pending count.
//
// Flow: one request at a time. For an add, the request passes the result
// stage into the output register. A dispatch streams all 32 table entries
// out of the sector RAM (32 reads, then a drain state for the registered read),
// picks, and passes the result stage before out_tvalid rises. A new request
// is accepted only once the scheduler is back in idle. in_tready is high whenever
// the scheduler is idle, even while a result waits in the output register.
//
// Reset (rst_n low, synchronous) empties the table, sets the head to
// sector 0 moving up, and drops any pending result. A stalled receiver
// holds the result in the output register; a second result waits in the
// result stage until the output register frees up.
`default_nettype none

module look_elevator_request_scheduler
  import lers_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [47:0] request_sector
  input  wire logic                  in_tuser,   // [0] opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [47:0] served_sector, [48] moving_down,
                                                 // [54:49] pending_count, [55] zero
  output logic      [1:0]            out_tuser   // [1:0] status
);

  state_t                   state_r, state_nxt;
  logic [QUEUE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [SECTOR_BITS-1:0]   head_r, head_nxt;
  logic                     dir_r, dir_nxt;

  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;

  logic                     ahead_f_r, ahead_f_nxt;
  logic [SECTOR_BITS-1:0]   ahead_s_r, ahead_s_nxt;
  logic [IDX_W-1:0]         ahead_i_r, ahead_i_nxt;
  logic                     rest_f_r, rest_f_nxt;
  logic [SECTOR_BITS-1:0]   rest_s_r, rest_s_nxt;
  logic [IDX_W-1:0]         rest_i_r, rest_i_nxt;

  status_t                  res_status_r, res_status_nxt;
  logic [SECTOR_BITS-1:0]   res_sector_r, res_sector_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [OUT_SECTOR_W-1:0]  out_sector_r, out_sector_nxt;
  logic                     out_down_r, out_down_nxt;
  logic [OUT_COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                     in_acc;
  logic                     full;
  logic [IDX_W-1:0]         free_idx;
  logic                     ram_we;
  logic [SECTOR_BITS-1:0]   in_sector;
  logic [SECTOR_BITS-1:0]   rd_sector;
  logic                     hit;
  logic                     is_ahead;
  logic                     better_ahead;
  logic                     better_rest;
  logic                     sel_f;
  logic [SECTOR_BITS-1:0]   sel_s;
  logic [IDX_W-1:0]         sel_i;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_sector = in_tdata[SECTOR_BITS-1:0];
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign ram_we    = in_acc && (in_tuser == OP_ADD) && !full;

  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  lers_ram #(
    .WIDTH (SECTOR_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_sector_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (in_sector),
    .raddr (scan_idx_r),
    .rdata (rd_sector)
  );

  // scan compare on the entry read last cycle
  assign hit          = cmp_en_r && valid_r[cmp_idx_r];
  assign is_ahead     = dir_r ? (rd_sector < head_r) : (rd_sector > head_r);
  assign better_ahead = !ahead_f_r ||
                        (dir_r ? (rd_sector > ahead_s_r) : (rd_sector < ahead_s_r));
  assign better_rest  = !rest_f_r ||
                        (dir_r ? (rd_sector < rest_s_r) : (rd_sector > rest_s_r));

  always_comb begin
    if (ahead_f_r) begin
      sel_f = 1'b1;
      sel_s = ahead_s_r;
      sel_i = ahead_i_r;
    end else begin
      sel_f = rest_f_r;
      sel_s = rest_s_r;
      sel_i = rest_i_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    dir_nxt        = dir_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_en_nxt     = 1'b0;
    cmp_idx_nxt    = scan_idx_r;
    ahead_f_nxt    = ahead_f_r;
    ahead_s_nxt    = ahead_s_r;
    ahead_i_nxt    = ahead_i_r;
    rest_f_nxt     = rest_f_r;
    rest_s_nxt     = rest_s_r;
    rest_i_nxt     = rest_i_r;
    res_status_nxt = res_status_r;
    res_sector_nxt = res_sector_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_sector_nxt = out_sector_r;
    out_down_nxt   = out_down_r;
    out_count_nxt  = out_count_r;

    if ((state_r == S_SCAN || state_r == S_DRAIN) && hit) begin
      if (is_ahead) begin
        if (better_ahead) begin
          ahead_f_nxt = 1'b1;
          ahead_s_nxt = rd_sector;
          ahead_i_nxt = cmp_idx_r;
        end
      end else if (better_rest) begin
        rest_f_nxt = 1'b1;
        rest_s_nxt = rd_sector;
        rest_i_nxt = cmp_idx_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_sector_nxt = '0;
          if (in_tuser == OP_ADD) begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              valid_nxt[free_idx] = 1'b1;
              count_nxt           = count_r + 1'b1;
              res_status_nxt      = ST_ADDED;
            end
            state_nxt = S_RES;
          end else begin
            scan_idx_nxt = '0;
            ahead_f_nxt  = 1'b0;
            rest_f_nxt   = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmp_en_nxt   = 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sel_f) begin
          valid_nxt[sel_i] = 1'b0;
          count_nxt        = count_r - 1'b1;
          dir_nxt          = !(sel_s > head_r);
          head_nxt         = sel_s;
          res_status_nxt   = ST_DISPATCHED;
          res_sector_nxt   = sel_s;
        end else begin
          res_status_nxt   = ST_EMPTY;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_sector_nxt = OUT_SECTOR_W'(res_sector_r);
          out_down_nxt   = dir_r;
          out_count_nxt  = OUT_COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      dir_r       <= 1'b0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      dir_r       <= dir_nxt;
      cmp_en_r    <= cmp_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    ahead_f_r    <= ahead_f_nxt;
    ahead_s_r    <= ahead_s_nxt;
    ahead_i_r    <= ahead_i_nxt;
    rest_f_r     <= rest_f_nxt;
    rest_s_r     <= rest_s_nxt;
    rest_i_r     <= rest_i_nxt;
    res_status_r <= res_status_nxt;
    res_sector_r <= res_sector_nxt;
    out_status_r <= out_status_nxt;
    out_sector_r <= out_sector_nxt;
    out_down_r   <= out_down_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_count_r, out_down_r, out_sector_r};

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("pending count out of step with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count beyond table depth");

  a_sector_zero_unless_dispatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_DISPATCHED) |-> out_sector_r == '0)
    else $error("served sector nonzero on non-dispatch result");

  a_result_from_res_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RES))
    else $error("result loaded outside result stage");

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN || state_r == S_PICK) |-> !ram_we)
    else $error("sector RAM written during dispatch scan");

endmodule

`default_nettype wire

@@ dv/lers_scoreboard.sv @@
`timescale 1ns / 1ps

module lers_scoreboard
  import lers_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic [1:0]            out_tuser,
  output int                         fail_count,
  output int                         backlog
);

  typedef struct packed {
    status_t                 status;
    logic [OUT_SECTOR_W-1:0] served;
    logic                    down;
    logic [OUT_COUNT_W-1:0]  count;
  } sched_result_t;

  sched_result_t          due_results[$];
  sched_result_t          oldest;
  logic [SECTOR_BITS-1:0] slot_sector [QUEUE_DEPTH];
  logic                   slot_busy   [QUEUE_DEPTH];
  logic [SECTOR_BITS-1:0] head_pos;
  logic                   head_down;
  int                     errors = 0;
  int                     waiting = 0;

  assign fail_count = errors;
  assign backlog    = waiting;

  // elevator order: nearest strictly ahead, else nearest of the rest behind or at the head
  function automatic sched_result_t serve_request(opcode_t op, logic [SECTOR_BITS-1:0] sector);
    sched_result_t r;
    int            ahead;
    int            rest;
    int            cnt;
    int            i;
    r        = '0;
    r.status = ST_FULL;
    ahead    = -1;
    rest     = -1;
    cnt      = 0;
    if (op == OP_ADD) begin
      for (i = 0; i < QUEUE_DEPTH; i++) begin
        if (!slot_busy[i] && r.status == ST_FULL) begin
          slot_busy[i]   = 1'b1;
          slot_sector[i] = sector;
          r.status       = ST_ADDED;
        end
      end
    end else begin
      for (i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_busy[i]) begin
          if (!head_down) begin
            if (slot_sector[i] > head_pos) begin
              if (ahead < 0 || slot_sector[i] < slot_sector[ahead]) ahead = i;
            end else if (rest < 0 || slot_sector[i] > slot_sector[rest]) begin
              rest = i;
            end
          end else begin
            if (slot_sector[i] < head_pos) begin
              if (ahead < 0 || slot_sector[i] > slot_sector[ahead]) ahead = i;
            end else if (rest < 0 || slot_sector[i] < slot_sector[rest]) begin
              rest = i;
            end
          end
        end
      end
      if (ahead < 0) ahead = rest;
      if (ahead < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.served         = slot_sector[ahead];
        slot_busy[ahead] = 1'b0;
        head_down        = !(slot_sector[ahead] > head_pos);
        head_pos         = slot_sector[ahead];
        r.status         = ST_DISPATCHED;
      end
    end
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_busy[i]) cnt++;
    end
    r.down  = head_down;
    r.count = cnt[OUT_COUNT_W-1:0];
    return r;
  endfunction

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_busy[i] = 1'b0;
      head_pos  = '0;
      head_down = 1'b0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          flag("unexpected result, tdata", '0, out_tdata);
        end else begin
          oldest = due_results.pop_front();
          if (out_tuser != oldest.status)
            flag("status", oldest.status, out_tuser);
          if (out_tdata[OUT_SECTOR_W-1:0] != oldest.served)
            flag("served_sector", oldest.served, out_tdata[OUT_SECTOR_W-1:0]);
          if (out_tdata[OUT_SECTOR_W] != oldest.down)
            flag("moving_down", oldest.down, out_tdata[OUT_SECTOR_W]);
          if (out_tdata[OUT_FIELDS_W-1:OUT_SECTOR_W+1] != oldest.count)
            flag("pending_count", oldest.count, out_tdata[OUT_FIELDS_W-1:OUT_SECTOR_W+1]);
          if (out_tdata[OUT_DATA_W-1:OUT_FIELDS_W] != '0)
            flag("tdata padding", '0, out_tdata[OUT_DATA_W-1:OUT_FIELDS_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(serve_request(opcode_t'(in_tuser), in_tdata[SECTOR_BITS-1:0]));
      end
    end
    waiting = due_results.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lers_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 133;
  localparam int DRAIN_CYCLES  = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tready = 1'b1;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  int fails;
  int backlog;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int idle_cycles  = 0;
  int n_add        = 0;
  int n_dispatch   = 0;
  int gap_plan[4]   = '{0, 60, 0, 21};
  int stall_plan[4] = '{0, 0, 60, 21};

  logic [SECTOR_BITS-1:0] recent_sectors[$];

  always #1 clk = ~clk;

  look_elevator_request_scheduler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lers_scoreboard sb (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fails),
    .backlog    (backlog)
  );

  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed", idle_cycles, backlog);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [SECTOR_BITS-1:0] pick_sector();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: return r[SECTOR_BITS-1:0];
      2: return SECTOR_BITS'($urandom_range(0, 40));
      3: return (recent_sectors.size() == 0) ? '0 :
                recent_sectors[$urandom_range(0, recent_sectors.size() - 1)];
      4: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: return r[SECTOR_BITS-1:0] >> $urandom_range(1, SECTOR_BITS - 1);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic push_request(opcode_t op, logic [SECTOR_BITS-1:0] sector);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= sector;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (op == OP_ADD) begin
      n_add++;
      recent_sectors.push_back(sector);
      if (recent_sectors.size() > 48) void'(recent_sectors.pop_front());
    end else begin
      n_dispatch++;
    end
  endtask

  initial begin
    int      sent;
    int      burst;
    int      mode;
    opcode_t op;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, then a sector sitting at the head
    push_request(OP_DISPATCH, '1);
    push_request(OP_ADD, '0);
    push_request(OP_DISPATCH, '0);
    // extremes and duplicate sectors
    push_request(OP_ADD, '1);
    push_request(OP_ADD, 48'h5555_5555_5555);
    push_request(OP_ADD, 48'hAAAA_AAAA_AAAA);
    push_request(OP_ADD, 48'hAAAA_AAAA_AAAA);
    push_request(OP_ADD, 48'h0000_0000_0001);
    repeat (6) push_request(OP_DISPATCH, 48'h1234_5678_9ABC);
    // head at top, same sector added again
    push_request(OP_ADD, '1);
    push_request(OP_ADD, 48'd7);
    repeat (3) push_request(OP_DISPATCH, '0);

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_plan[ph];
      stall_pct = stall_plan[ph];
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        mode  = $urandom_range(0, 3);
        burst = $urandom_range(4, 40);
        for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
          case (mode)
            0:       op = OP_ADD;
            1:       op = OP_DISPATCH;
            default: op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_DISPATCH;
          endcase
          push_request(op, pick_sector());
          sent++;
        end
      end
    end
    in_tvalid <= 1'b0;

    while (backlog != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d requests: %0d adds, %0d dispatches", n_add + n_dispatch,
             n_add, n_dispatch);
    $display("flow phases: free-running, sender gaps, receiver stalls, both combined");
    if (fails == 0 && backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/lers_pkg.sv
sv/lers_ram.sv
sv/look_elevator_request_scheduler.sv
dv/lers_scoreboard.sv
dv/tb_top.sv
